// ===== rtl/data_run_list_decoder_unit_defines.svh =====
// Assertion macros for the run list decoder top level.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef DATA_RUN_LIST_DECODER_UNIT_DEFINES_SVH
`define DATA_RUN_LIST_DECODER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DRLD_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define DRLD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies another in the next cycle.
`define DRLD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/drld_pkg.sv =====
package drld_pkg;

	// Field widths of the run list format.
	localparam int BYTE_W = 8;
	localparam int WORD_W = 64;
	localparam int LANES  = WORD_W / BYTE_W;

	// Defaults and limits.
	localparam int             RUN_LIMIT_DEF  = 128;
	localparam logic [7:0]     BUDGET_RESET   = 8'd128;
	localparam logic [3:0]     SIZE_MAX       = 4'd8;

	// Result status codes.
	localparam logic [1:0] STATUS_RUN = 2'd0;
	localparam logic [1:0] STATUS_END = 2'd1;
	localparam logic [1:0] STATUS_ERR = 2'd2;

	// Parse phase, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_LENGTH = 4'b0100,
		PH_OFFSET = 4'b1000
	} phase_t;

	// One input item.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              list_start;
	} byte_item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] first_vcn;
		logic [WORD_W-1:0] first_lcn;
		logic [WORD_W-1:0] run_length;
		logic              sparse;
		logic [7:0]        run_total;
		logic              last;
	} run_item_t;

endpackage

// ===== rtl/drld_ifs.sv =====
// Byte input channel.
interface drld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       list_start;

	modport source (output valid, data_byte, list_start, input ready);
	modport sink   (input valid, data_byte, list_start, output ready);
endinterface

// Decoded run output channel.
interface drld_run_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] first_vcn;
	logic [63:0] first_lcn;
	logic [63:0] run_length;
	logic        sparse;
	logic [7:0]  run_total;
	logic        last;

	modport source (output valid, status, first_vcn, first_lcn, run_length, sparse,
		run_total, last, input ready);
	modport sink   (input valid, status, first_vcn, first_lcn, run_length, sparse,
		run_total, last, output ready);
endinterface

// Configuration write channel for the run budget.
interface drld_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] run_budget;

	modport source (output valid, run_budget, input ready);
	modport sink   (input valid, run_budget, output ready);
endinterface

// ===== rtl/drld_in_stage.sv =====
module drld_in_stage
	import drld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  byte_item_t in_item,
	output logic       in_ready,
	input  logic       consume,
	output logic       s1_valid,
	output byte_item_t s1_item
);

	logic       valid_s1;
	byte_item_t item_s1;

	// The stage refills in the same cycle that its item is consumed.
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

// ===== rtl/drld_core.sv =====
module drld_core
	import drld_pkg::*;
#(
	parameter int RUN_LIMIT = RUN_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  byte_item_t item,
	input  logic [7:0] run_budget,
	output logic       res_gen,
	output run_item_t  res
);

	localparam int CNT_W = $clog2(RUN_LIMIT + 1);

	phase_t              phase_q, phase_d, phase_cur;
	logic [3:0]          len_left_q, len_left_d;
	logic [3:0]          off_left_q, off_left_d;
	logic [2:0]          pos_q, pos_d;
	logic [WORD_W-1:0]   len_acc_q, len_acc_d;
	logic [WORD_W-1:0]   off_acc_q, off_acc_d;
	logic [WORD_W-1:0]   vcn_q, vcn_d;
	logic [WORD_W-1:0]   lcn_q, lcn_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [CNT_W:0]      lim;
	logic [CNT_W:0]      cnt_inc;
	logic [WORD_W-1:0]   len_merge, off_merge, off_ext;
	logic [WORD_W-1:0]   fin_len, vcn_sum, lcn_sum;
	logic                finish, fin_sparse, fin_last;
	logic [3:0]          lsz, osz;

	// Effective run limit: zero acts as one, capped at the build limit.
	always_comb begin
		if (run_budget == 8'd0) begin
			lim = (CNT_W+1)'(1);
		end else if (int'(run_budget) > RUN_LIMIT) begin
			lim = (CNT_W+1)'(RUN_LIMIT);
		end else begin
			lim = (CNT_W+1)'(run_budget);
		end
	end

	// Place the byte in its lane and build the sign fill above it.
	always_comb begin
		len_merge = len_acc_q;
		off_merge = off_acc_q;
		off_ext   = '0;
		for (int i = 0; i < LANES; i++) begin
			if (pos_q == 3'(i)) begin
				len_merge[i*BYTE_W +: BYTE_W] = len_acc_q[i*BYTE_W +: BYTE_W] | item.data_byte;
				off_merge[i*BYTE_W +: BYTE_W] = off_acc_q[i*BYTE_W +: BYTE_W] | item.data_byte;
			end
			if (item.data_byte[BYTE_W-1] && (3'(i) > pos_q)) begin
				off_ext[i*BYTE_W +: BYTE_W] = '1;
			end
		end
	end

	// Parse step for one byte.
	always_comb begin
		lsz        = item.data_byte[3:0];
		osz        = item.data_byte[7:4];
		phase_cur  = item.list_start ? PH_HEADER : phase_q;
		phase_d    = phase_cur;
		len_left_d = len_left_q;
		off_left_d = off_left_q;
		pos_d      = pos_q;
		len_acc_d  = len_acc_q;
		off_acc_d  = off_acc_q;
		vcn_d      = item.list_start ? '0 : vcn_q;
		lcn_d      = item.list_start ? '0 : lcn_q;
		cnt_d      = item.list_start ? '0 : cnt_q;
		finish     = 1'b0;
		fin_sparse = 1'b0;
		fin_len    = len_acc_q;
		res_gen    = 1'b0;
		res        = '0;
		res.run_total = 8'(cnt_d);

		case (phase_cur)
			PH_HEADER: begin
				if (item.data_byte == '0) begin
					phase_d    = PH_IDLE;
					res_gen    = 1'b1;
					res.status = STATUS_END;
					res.last   = 1'b1;
				end else if (lsz == 4'd0 || lsz > SIZE_MAX || osz > SIZE_MAX) begin
					phase_d    = PH_IDLE;
					res_gen    = 1'b1;
					res.status = STATUS_ERR;
					res.last   = 1'b1;
				end else begin
					len_left_d = lsz;
					off_left_d = osz;
					pos_d      = '0;
					len_acc_d  = '0;
					off_acc_d  = '0;
					phase_d    = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				len_acc_d  = len_merge;
				pos_d      = pos_q + 3'd1;
				len_left_d = len_left_q - 4'd1;
				if (len_left_q == 4'd1) begin
					pos_d = '0;
					if (off_left_q == 4'd0) begin
						finish     = 1'b1;
						fin_sparse = 1'b1;
						fin_len    = len_merge;
					end else begin
						phase_d = PH_OFFSET;
					end
				end
			end
			PH_OFFSET: begin
				off_acc_d  = off_merge;
				pos_d      = pos_q + 3'd1;
				off_left_d = off_left_q - 4'd1;
				if (off_left_q == 4'd1) begin
					pos_d  = '0;
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Run completion: advance the running clusters and the count.
		vcn_sum  = vcn_q + fin_len;
		lcn_sum  = lcn_q + (off_merge | off_ext);
		cnt_inc  = {1'b0, cnt_q} + (CNT_W+1)'(1);
		fin_last = (cnt_inc >= lim);
		if (finish) begin
			vcn_d          = vcn_sum;
			lcn_d          = fin_sparse ? lcn_q : lcn_sum;
			cnt_d          = cnt_inc[CNT_W-1:0];
			phase_d        = fin_last ? PH_IDLE : PH_HEADER;
			res_gen        = 1'b1;
			res.status     = STATUS_RUN;
			res.first_vcn  = vcn_q;
			res.first_lcn  = fin_sparse ? '0 : lcn_sum;
			res.run_length = fin_len;
			res.sparse     = fin_sparse;
			res.run_total  = 8'(cnt_inc);
			res.last       = fin_last;
		end
	end

	// Parse control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			len_left_q <= '0;
			off_left_q <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			len_left_q <= len_left_d;
			off_left_q <= off_left_d;
			pos_q      <= pos_d;
			cnt_q      <= cnt_d;
		end
	end

	// Accumulators and running clusters.
	always_ff @(posedge clk) begin
		if (fire) begin
			len_acc_q <= len_acc_d;
			off_acc_q <= off_acc_d;
			vcn_q     <= vcn_d;
			lcn_q     <= lcn_d;
		end
	end

endmodule

// ===== rtl/drld_out_stage.sv =====
module drld_out_stage
	import drld_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  run_item_t res,
	input  logic      out_ready,
	output logic      out_free,
	output logic      out_valid,
	output run_item_t out_item
);

	logic      valid_q;
	run_item_t item_q;

	// The register can take a new result when empty or being drained.
	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			item_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

// ===== rtl/data_run_list_decoder_unit.sv =====
// Channel   Role    Fields
// byte_in   sink    data_byte, list_start
// run_out   source  status, first_vcn, first_lcn, run_length, sparse, run_total, last
// cfg       sink    run_budget, always ready
//
// One byte is accepted per cycle unless a result stalls; each passes the single parse stage.
// The ending byte goes to the input register, then its result to the result register.
// A byte that yields no result moves on even while a result waits to be taken.
// A byte that ends a result waits only while the result register is held by run_out.ready.
// Reset idles the decoder; run_budget returns to 128 and a list needs list_start to begin.
`include "data_run_list_decoder_unit_defines.svh"

module data_run_list_decoder_unit
	import drld_pkg::*;
#(
	parameter int RUN_LIMIT = RUN_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	drld_byte_if.sink  byte_in,
	drld_run_if.source run_out,
	drld_cfg_if.sink   cfg
);

	logic       cfg_seen_q;
	logic [7:0] run_budget_q;
	byte_item_t in_item, s1_item;
	logic       s1_valid, fire, res_gen, out_free, out_valid;
	run_item_t  res, out_item;

	// Configuration register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_seen_q   <= 1'b0;
			run_budget_q <= BUDGET_RESET;
		end else if (cfg.valid) begin
			cfg_seen_q   <= 1'b1;
			run_budget_q <= cfg.run_budget;
		end
	end

	// Input register.
	assign in_item.data_byte  = byte_in.data_byte;
	assign in_item.list_start = byte_in.list_start;

	drld_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_in.valid),
		.in_item  (in_item),
		.in_ready (byte_in.ready),
		.consume  (fire),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	// A byte moves on unless its result would meet a full result register.
	assign fire = s1_valid && (!res_gen || out_free);

	drld_core #(
		.RUN_LIMIT (RUN_LIMIT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (s1_item),
		.run_budget (run_budget_q),
		.res_gen    (res_gen),
		.res        (res)
	);

	drld_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_gen),
		.res       (res),
		.out_ready (run_out.ready),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// Result channel.
	assign run_out.valid      = out_valid;
	assign run_out.status     = out_item.status;
	assign run_out.first_vcn  = out_item.first_vcn;
	assign run_out.first_lcn  = out_item.first_lcn;
	assign run_out.run_length = out_item.run_length;
	assign run_out.sparse     = out_item.sparse;
	assign run_out.run_total  = out_item.run_total;
	assign run_out.last       = out_item.last;

	// Checks on the result path.
	`DRLD_ASSERT_IMP(a_end_is_last, out_valid && out_item.status != STATUS_RUN,
		out_item.last, "end or error item without last")
	`DRLD_ASSERT_IMP(a_sparse_lcn, out_valid && out_item.sparse,
		out_item.first_lcn == '0 && out_item.status == STATUS_RUN, "sparse run with a cluster")
	`DRLD_ASSERT(a_count_cap,
		!out_valid || int'(out_item.run_total) <= RUN_LIMIT || !cfg_seen_q,
		"run count beyond limit")
	`DRLD_ASSERT_NXT(a_result_held, fire && res_gen, out_valid, "result item lost")

endmodule
